FILE: rtl/core/mfe_pkg.sv
// Shared types, constants and helpers for the move-to-front Fibonacci encoder.
`default_nettype none
package mfe_pkg;

  // Per-request control that travels with a rank through the queue
  typedef struct packed {
    logic sym_valid;
    logic eoi;
  } mfe_ctl_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } mfe_qstat_t;

  localparam int FIB_N = 32;

  // Fibonacci numbers F(0)..F(31), F(1) = F(2) = 1
  localparam logic [31:0] FIB_TAB [FIB_N] = '{
    32'd0, 32'd1, 32'd1, 32'd2, 32'd3, 32'd5, 32'd8, 32'd13,
    32'd21, 32'd34, 32'd55, 32'd89, 32'd144, 32'd233, 32'd377, 32'd610,
    32'd987, 32'd1597, 32'd2584, 32'd4181, 32'd6765, 32'd10946, 32'd17711, 32'd28657,
    32'd46368, 32'd75025, 32'd121393, 32'd196418, 32'd317811, 32'd514229,
    32'd832040, 32'd1346269
  };

  // Largest index k with F(k) <= maxn, at least 2 (elaboration only)
  function automatic int fib_top(input int maxn);
    int k;
    k = 2;
    for (int i = 2; i < FIB_N; i++) begin
      if (FIB_TAB[i] <= 32'(maxn)) k = i;
    end
    return k;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/mtf_fibonacci_encoder.sv
// Top level of the move-to-front Fibonacci encoder.
//
// Channel   Direction  Handshake            Payload
// in_       request    in_valid/in_stall    in_symbol, in_symbol_valid, in_end_of_input
// out_      result     out_valid/out_stall  out_byte, out_last_of_run, out_stream_done
//
// Ranking walks the recency list one entry at a time, reading and then comparing each entry;
// a new symbol is appended at the tail unless the list is full, when the last entry drops.
// Coding in the back end can wait on output stalls and overlaps the next ranking.
// Reset clears the list fill count, the bit packer and both handshakes; no clearing pass.
// A stalled output holds its byte; the coder waits when a finished byte cannot move on.
`default_nettype none
module mtf_fibonacci_encoder #(
  parameter int SYMBOL_BITS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SYMBOL_BITS-1:0] in_symbol,
  input  wire logic                   in_symbol_valid,
  input  wire logic                   in_end_of_input,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [7:0]                  out_byte,
  output logic                        out_last_of_run,
  output logic                        out_stream_done
);
  import mfe_pkg::*;

  logic                 q_push, q_pop;
  mfe_ctl_t             push_ctl, pop_ctl;
  logic [SYMBOL_BITS:0] push_rank, pop_rank;
  mfe_qstat_t           q_stat;

  mfe_ranker #(.SYMBOL_BITS(SYMBOL_BITS)) u_ranker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_symbol      (in_symbol),
    .in_symbol_valid(in_symbol_valid),
    .in_end_of_input(in_end_of_input),
    .q_push         (q_push),
    .q_ctl          (push_ctl),
    .q_rank         (push_rank),
    .q_stat         (q_stat)
  );

  mfe_queue #(.RW(SYMBOL_BITS + 1)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ctl (push_ctl),
    .push_rank(push_rank),
    .pop      (q_pop),
    .pop_ctl  (pop_ctl),
    .pop_rank (pop_rank),
    .stat     (q_stat)
  );

  mfe_packer #(.SYMBOL_BITS(SYMBOL_BITS)) u_packer (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_pop          (q_pop),
    .q_ctl          (pop_ctl),
    .q_rank         (pop_rank),
    .q_stat         (q_stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last_of_run(out_last_of_run),
    .out_stream_done(out_stream_done)
  );

`ifndef NO_ASSERTIONS
  // Never push into a full queue or pop an empty one
  a_q_push: assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_stat.full))
    else $error("push into full queue");
  a_q_pop: assert property (@(posedge clk) disable iff (!rst_n) !(q_pop && q_stat.empty))
    else $error("pop from empty queue");
  // A flush byte always closes its request
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stream_done) |-> out_last_of_run)
    else $error("flush byte not marked last");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/mfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: rtl/core/mfe_ranker.sv
// Front end: accepts symbols, walks the recency list and produces move-to-front ranks.
`default_nettype none
module mfe_ranker #(
  parameter int SYMBOL_BITS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SYMBOL_BITS-1:0] in_symbol,
  input  wire logic                   in_symbol_valid,
  input  wire logic                   in_end_of_input,
  output logic                        q_push,
  output mfe_pkg::mfe_ctl_t           q_ctl,
  output logic [SYMBOL_BITS:0]        q_rank,
  input  wire mfe_pkg::mfe_qstat_t    q_stat
);
  import mfe_pkg::*;

  localparam int Alpha = 2 ** SYMBOL_BITS;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_RD   = 3'd1;
  localparam logic [2:0] F_CMP  = 3'd2;
  localparam logic [2:0] F_APP  = 3'd3;
  localparam logic [2:0] F_PUT  = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [SYMBOL_BITS-1:0] sym_r, sym_nxt;
  mfe_ctl_t               ctl_r, ctl_nxt;
  logic [SYMBOL_BITS-1:0] i_r, i_nxt;
  logic [SYMBOL_BITS-1:0] carry_r, carry_nxt;
  logic [SYMBOL_BITS:0]   count_r, count_nxt;
  logic [SYMBOL_BITS:0]   rank_r, rank_nxt;

  logic                   wr_en;
  logic [SYMBOL_BITS-1:0] wr_addr;
  logic [SYMBOL_BITS-1:0] wr_data;
  logic                   rd_en;
  logic [SYMBOL_BITS-1:0] rd_data;
  logic                   at_tail;

  mfe_ram #(
    .WIDTH(SYMBOL_BITS),
    .DEPTH(Alpha)
  ) u_list (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(i_r),
    .rd_data(rd_data)
  );

  assign in_stall = (state_r != F_IDLE);
  assign at_tail  = ({1'b0, i_r} == (count_r - (SYMBOL_BITS + 1)'(1)));
  assign rd_en    = (state_r == F_RD);
  assign q_push   = (state_r == F_PUT) && !q_stat.full;
  assign q_ctl    = ctl_r;
  assign q_rank   = rank_r;

  // Walk the list: write the carried entry back one place down, stop at a match or the tail
  always_comb begin
    state_nxt = state_r;
    sym_nxt   = sym_r;
    ctl_nxt   = ctl_r;
    i_nxt     = i_r;
    carry_nxt = carry_r;
    count_nxt = count_r;
    rank_nxt  = rank_r;
    wr_en     = 1'b0;
    wr_addr   = i_r;
    wr_data   = carry_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          sym_nxt       = in_symbol;
          ctl_nxt.sym_valid = in_symbol_valid;
          ctl_nxt.eoi   = in_end_of_input;
          i_nxt         = '0;
          carry_nxt     = in_symbol;
          rank_nxt      = {1'b1, in_symbol};
          if (!in_symbol_valid) begin
            state_nxt = F_PUT;
          end else if (count_r == '0) begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = in_symbol;
            count_nxt = (SYMBOL_BITS + 1)'(1);
            state_nxt = F_PUT;
          end else begin
            state_nxt = F_RD;
          end
        end
      end
      F_RD: begin
        state_nxt = F_CMP;
      end
      F_CMP: begin
        wr_en = 1'b1;
        if (rd_data == sym_r) begin
          rank_nxt  = {1'b0, i_r};
          state_nxt = F_PUT;
        end else begin
          carry_nxt = rd_data;
          if (at_tail) begin
            rank_nxt  = {1'b1, sym_r};
            state_nxt = count_r[SYMBOL_BITS] ? F_PUT : F_APP;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = F_RD;
          end
        end
      end
      F_APP: begin
        wr_en     = 1'b1;
        wr_addr   = count_r[SYMBOL_BITS-1:0];
        count_nxt = count_r + 1'b1;
        state_nxt = F_PUT;
      end
      F_PUT: begin
        if (!q_stat.full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    sym_r   <= sym_nxt;
    ctl_r   <= ctl_nxt;
    i_r     <= i_nxt;
    carry_r <= carry_nxt;
    rank_r  <= rank_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/core/mfe_queue.sv
// Two-entry queue carrying ranks from the front end to the coder.
`default_nettype none
module mfe_queue #(
  parameter int RW = 9
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire mfe_pkg::mfe_ctl_t   push_ctl,
  input  wire logic [RW-1:0]       push_rank,
  input  wire logic                pop,
  output mfe_pkg::mfe_ctl_t        pop_ctl,
  output logic [RW-1:0]            pop_rank,
  output mfe_pkg::mfe_qstat_t      stat
);
  import mfe_pkg::*;

  mfe_ctl_t      ctl_r  [2];
  logic [RW-1:0] rank_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign pop_ctl    = ctl_r[rp_r];
  assign pop_rank   = rank_r[rp_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      ctl_r[wp_r]  <= push_ctl;
      rank_r[wp_r] <= push_rank;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/mfe_packer.sv
// Back end: Fibonacci codes each rank and packs the code bits MSB first into bytes.
`default_nettype none
module mfe_packer #(
  parameter int SYMBOL_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  output logic                     q_pop,
  input  wire mfe_pkg::mfe_ctl_t   q_ctl,
  input  wire logic [SYMBOL_BITS:0] q_rank,
  input  wire mfe_pkg::mfe_qstat_t q_stat,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               out_byte,
  output logic                     out_last_of_run,
  output logic                     out_stream_done
);
  import mfe_pkg::*;

  localparam int NW     = SYMBOL_BITS + 2;
  localparam int FibTop = fib_top(2 ** (SYMBOL_BITS + 1));
  localparam int CwW    = FibTop - 1;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_FIB  = 2'd1;
  localparam logic [1:0] B_PUSH = 2'd2;
  localparam logic [1:0] B_END  = 2'd3;

  logic [1:0]     state_r, state_nxt;
  logic           eoi_r, eoi_nxt;
  logic [NW-1:0]  rem_r, rem_nxt;
  logic [4:0]     idx_r, idx_nxt;
  logic           started_r, started_nxt;
  logic [CwW-1:0] cw_r, cw_nxt;
  logic [4:0]     len_r, len_nxt;
  logic [7:0]     acc_r, acc_nxt;
  logic [2:0]     cnt_r, cnt_nxt;
  logic [7:0]     pend_r, pend_nxt;
  logic           pend_v_r, pend_v_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_byte_r, out_byte_nxt;
  logic           out_last_r, out_last_nxt;
  logic           out_done_r, out_done_nxt;

  logic           out_free;
  logic           out_load;
  logic [NW-1:0]  fib_f;
  logic           ge;
  logic           bit_in;
  logic           flush;

  assign out_free = !out_valid_r || !out_stall;
  assign fib_f    = NW'(FIB_TAB[idx_r]);
  assign ge       = (fib_f <= rem_r);
  assign bit_in   = (len_r == '0) ? 1'b1 : cw_r[0];
  assign flush    = eoi_r && (cnt_r != '0);
  assign q_pop    = (state_r == B_IDLE) && !q_stat.empty;

  // Sequence code, pack and flush
  always_comb begin
    state_nxt    = state_r;
    eoi_nxt      = eoi_r;
    rem_nxt      = rem_r;
    idx_nxt      = idx_r;
    started_nxt  = started_r;
    cw_nxt       = cw_r;
    len_nxt      = len_r;
    acc_nxt      = acc_r;
    cnt_nxt      = cnt_r;
    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;
    out_load     = 1'b0;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    out_done_nxt = out_done_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          eoi_nxt     = q_ctl.eoi;
          rem_nxt     = NW'(q_rank) + NW'(1);
          idx_nxt     = 5'(FibTop);
          started_nxt = 1'b0;
          cw_nxt      = '0;
          len_nxt     = '0;
          state_nxt   = q_ctl.sym_valid ? B_FIB : B_END;
        end
      end
      B_FIB: begin
        // Greedy Zeckendorf step, largest term first
        if (ge) begin
          rem_nxt     = rem_r - fib_f;
          started_nxt = 1'b1;
        end
        if (ge || started_r) begin
          cw_nxt  = {cw_r[CwW-2:0], ge};
          len_nxt = len_r + 1'b1;
        end
        idx_nxt = idx_r - 1'b1;
        if (idx_r == 5'd2) state_nxt = B_PUSH;
      end
      B_PUSH: begin
        // Hold when a byte completes while the pending byte cannot leave
        if (!((cnt_r == 3'd7) && pend_v_r && !out_free)) begin
          acc_nxt = {acc_r[6:0], bit_in};
          cnt_nxt = cnt_r + 1'b1;
          cw_nxt  = cw_r >> 1;
          if (cnt_r == 3'd7) begin
            if (pend_v_r) begin
              out_load     = 1'b1;
              out_byte_nxt = pend_r;
              out_last_nxt = 1'b0;
              out_done_nxt = 1'b0;
            end
            pend_nxt   = {acc_r[6:0], bit_in};
            pend_v_nxt = 1'b1;
          end
          if (len_r == '0) begin
            state_nxt = B_END;
          end else begin
            len_nxt = len_r - 1'b1;
          end
        end
      end
      B_END: begin
        if (pend_v_r) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_byte_nxt = pend_r;
            out_last_nxt = !flush;
            out_done_nxt = 1'b0;
            pend_v_nxt   = 1'b0;
          end
        end else if (flush) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_byte_nxt = 8'(acc_r << (4'd8 - {1'b0, cnt_r}));
            out_last_nxt = 1'b1;
            out_done_nxt = 1'b1;
            cnt_nxt      = '0;
            state_nxt    = B_IDLE;
          end
        end else begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    eoi_r      <= eoi_nxt;
    rem_r      <= rem_nxt;
    idx_r      <= idx_nxt;
    started_r  <= started_nxt;
    cw_r       <= cw_nxt;
    len_r      <= len_nxt;
    acc_r      <= acc_nxt;
    pend_r     <= pend_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;
  assign out_stream_done = out_done_r;

endmodule
`default_nettype wire

FILE: tb/sv/mfe_checker.sv
// Request/result monitor with move-to-front Fibonacci predictor for the encoder.
`timescale 1ns / 100ps
module mfe_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [7:0] in_symbol,
  input  wire logic       in_symbol_valid,
  input  wire logic       in_end_of_input,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [7:0] out_byte,
  input  wire logic       out_last_of_run,
  input  wire logic       out_stream_done,
  output int              fail_count,
  output int              pending_bytes
);

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last;
    logic       done;
  } code_byte_t;

  code_byte_t  byte_q[$];
  logic [7:0]  recency[256];
  bit          seen[256];
  int          seen_num;
  logic [31:0] fib[32];
  logic [31:0] pack_bits;
  int          pack_num;

  initial begin
    fib[0] = 0;
    fib[1] = 1;
    for (int i = 2; i < 32; i++) fib[i] = fib[i-1] + fib[i-2];
  end

  assign pending_bytes = byte_q.size();

  // Rank a symbol and move it to the front
  function automatic int rank_symbol(input logic [7:0] sym);
    int pos;
    int rank;
    bit found;
    pos = 0;
    found = 0;
    if (seen[sym]) begin
      for (int i = 0; i < seen_num; i++) begin
        if (!found && recency[i] == sym) begin
          pos = i;
          found = 1;
        end
      end
    end
    if (found) begin
      rank = pos;
    end else begin
      rank = int'(sym) + 256;
      pos = (seen_num < 256) ? seen_num : 255;
      if (seen_num < 256) seen_num++;
      seen[sym] = 1;
    end
    for (int i = pos; i > 0; i--) recency[i] = recency[i-1];
    recency[0] = sym;
    return rank;
  endfunction

  // Append the Zeckendorf code of n plus its terminating one
  function automatic void append_code(input int n);
    int top;
    int rem;
    bit used[32];
    top = 2;
    rem = n;
    for (int i = 0; i < 32; i++) used[i] = 0;
    while (top + 1 < 32 && fib[top+1] <= n) top++;
    for (int i = top; i >= 2; i--) begin
      if (fib[i] <= rem) begin
        used[i] = 1;
        rem -= fib[i];
      end
    end
    for (int i = 2; i <= top; i++) begin
      pack_bits = {pack_bits[30:0], used[i]};
      pack_num++;
    end
    pack_bits = {pack_bits[30:0], 1'b1};
    pack_num++;
  endfunction

  // Predict the bytes one request causes
  function automatic void predict_request(input logic [7:0] sym, input logic sv,
                                          input logic eoi);
    code_byte_t e;
    int made;
    made = 0;
    if (sv) begin
      append_code(rank_symbol(sym) + 1);
      while (pack_num >= 8) begin
        e.code_byte = 8'(pack_bits >> (pack_num - 8));
        e.last = 0;
        e.done = 0;
        byte_q.push_back(e);
        made++;
        pack_num -= 8;
        pack_bits &= (32'd1 << pack_num) - 1;
      end
    end
    if (eoi && pack_num > 0) begin
      e.code_byte = 8'(pack_bits << (8 - pack_num));
      e.last = 0;
      e.done = 1;
      byte_q.push_back(e);
      made++;
      pack_bits = 0;
      pack_num = 0;
    end
    if (made > 0) byte_q[byte_q.size()-1].last = 1;
  endfunction

  // Watch both channels; clear the model while in reset
  always @(posedge clk) begin
    code_byte_t e;
    if (!rst_n) begin
      for (int i = 0; i < 256; i++) seen[i] = 0;
      seen_num   = 0;
      pack_bits  = 0;
      pack_num   = 0;
      fail_count = 0;
      byte_q.delete();
    end else begin
      if (in_valid && !in_stall) predict_request(in_symbol, in_symbol_valid, in_end_of_input);
      if (out_valid && !out_stall) begin
        if (byte_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected byte %02h last=%0d done=%0d", out_byte, out_last_of_run,
                     out_stream_done);
        end else begin
          e = byte_q.pop_front();
          if (out_byte !== e.code_byte || out_last_of_run !== e.last ||
              out_stream_done !== e.done) begin
            fail_count++;
            if (fail_count <= 10)
              $display("byte mismatch: expected %02h/%0d/%0d got %02h/%0d/%0d",
                       e.code_byte, e.last, e.done, out_byte, out_last_of_run,
                       out_stream_done);
          end
        end
      end
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Stimulus and verdict for the move-to-front Fibonacci encoder.
`timescale 1ns / 100ps
module testbench;

  localparam int IdleLimit = 20000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_symbol;
  logic       in_symbol_valid;
  logic       in_end_of_input;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last_of_run;
  logic       out_stream_done;
  int         fail_count;
  int         pending_bytes;
  int         idle_cycles;
  int         burst_left;
  logic [7:0] pool[8];

  mtf_fibonacci_encoder #(.SYMBOL_BITS(8)) dut (.*);

  mfe_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel in alternating quiet and busy stretches
  always @(posedge clk) begin
    if (($time / 2000) % 3 == 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 40);
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one request and hold it until accepted
  task automatic send(input logic [7:0] sym, input logic sv, input logic eoi);
    int gap;
    in_valid        <= 1'b1;
    in_symbol       <= sym;
    in_symbol_valid <= sv;
    in_end_of_input <= eoi;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    logic [7:0] sym;
    int pick;
    rst_n = 0;
    in_valid = 0;
    in_symbol = 0;
    in_symbol_valid = 0;
    in_end_of_input = 0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty flush, no-symbol item, extremes, repeats, flush after data
    send(8'h00, 1'b0, 1'b1);
    send(8'h00, 1'b0, 1'b0);
    send(8'h00, 1'b1, 1'b0);
    send(8'hFF, 1'b1, 1'b0);
    send(8'hFF, 1'b1, 1'b0);
    send(8'h00, 1'b1, 1'b0);
    send(8'hAA, 1'b1, 1'b0);
    send(8'h55, 1'b1, 1'b1);
    send(8'h55, 1'b0, 1'b1);
    send(8'hFF, 1'b1, 1'b0);
    send(8'h00, 1'b1, 1'b1);
    send(8'h80, 1'b1, 1'b0);
    send(8'h01, 1'b1, 1'b0);
    send(8'h7F, 1'b1, 1'b0);
    send(8'hFE, 1'b1, 1'b0);
    send(8'h80, 1'b0, 1'b1);
    send(8'hFE, 1'b1, 1'b1);

    // Random: mostly a small working set, some fresh symbols, flushes and empty items
    for (int i = 0; i < 8; i++) pool[i] = 8'($urandom_range(0, 255));
    for (int n = 0; n < 320; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) sym = pool[$urandom_range(0, 7)];
      else sym = 8'($urandom_range(0, 255));
      if (pick >= 95) pool[$urandom_range(0, 7)] = sym;
      send(sym, $urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0);
    end
    send(8'h00, 1'b0, 1'b1);
    in_valid <= 1'b0;

    // Drain, then allow for the longest list walk
    while (pending_bytes != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (fail_count == 0 && pending_bytes == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
